// File: design/rcwp_pkg.sv
// shared constants for the raycast wall column projection unit
// no dependencies
package rcwp_pkg;

    localparam int DIST_W = 32;
    localparam int QUOT_W = 16;
    localparam int TEXW_W = 13;
    localparam int COL_W  = 12;
    localparam int ROW_W  = 10;
    localparam int TEX_W  = 2;

    localparam logic [TEXW_W-1:0] TEX_WIDTH_MAX = 13'd4096;
    localparam logic [TEXW_W-1:0] TEX_WIDTH_MIN = 13'd1;

    typedef enum logic [TEX_W-1:0] {
        TEX_WEST  = 2'd0,
        TEX_EAST  = 2'd1,
        TEX_NORTH = 2'd2,
        TEX_SOUTH = 2'd3
    } tex_t;

    typedef enum logic [1:0] {
        CFG_WEST_WIDTH  = 2'd0,
        CFG_EAST_WIDTH  = 2'd1,
        CFG_NORTH_WIDTH = 2'd2,
        CFG_SOUTH_WIDTH = 2'd3
    } cfg_idx_t;

endpackage

// File: design/rcwp_div_step.sv
// two quotient bits of the restoring line height divider
// depends on rcwp_pkg
module rcwp_div_step
    import rcwp_pkg::*;
(
    input  logic [DIST_W:0]   rem_in,
    input  logic [QUOT_W-1:0] quot_in,
    input  logic [DIST_W-1:0] divisor,
    input  logic [1:0]        num_bits,
    output logic [DIST_W:0]   rem_out,
    output logic [QUOT_W-1:0] quot_out
);

    logic [DIST_W:0] r_a;
    logic [DIST_W:0] r_b;
    logic [DIST_W:0] r_c;
    logic [DIST_W:0] r_d;
    logic            q_a;
    logic            q_b;

    always_comb
    begin
        // remainder stays below the divisor, so its top bit is always clear
        r_a = {rem_in[DIST_W-1:0], num_bits[1]};
        q_a = (r_a >= {1'b0, divisor});
        r_b = q_a ? (r_a - {1'b0, divisor}) : r_a;
        r_c = {r_b[DIST_W-1:0], num_bits[0]};
        q_b = (r_c >= {1'b0, divisor});
        r_d = q_b ? (r_c - {1'b0, divisor}) : r_c;
        rem_out  = r_d;
        quot_out = {quot_in[QUOT_W-3:0], q_a, q_b};
    end

endmodule

// File: design/raycast_wall_column_projection_unit.sv
// top level of the raycast wall column projection unit
// depends on rcwp_pkg and rcwp_div_step
//
// usage:
//   in channel (in_valid/in_ready) takes one finished ray word per screen
//   column; out channel (out_valid/out_ready) gives its projection word.
//   cfg channel writes one of the four face texture widths by cfg_index;
//   cfg_ready is always high, write only while the pipe is empty.
// throughput: one ray per cycle while out_ready is high. the pipe depth is
//   set by the line height divider, two quotient bits per stage over eight
//   stages, plus distance, multiply and row stages.
// stalls: each stage holds its word while the stage after it is full and
//   stalled, so bubbles are squeezed out and in_ready stays high while any
//   stage is empty; nothing is dropped or repeated.
// reset: all stage valid bits clear, texture widths return to 64.
//
module raycast_wall_column_projection_unit
    import rcwp_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 1024,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [TEXW_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  hit_side,
    input  logic [DIST_W-1:0]     side_dist_x,
    input  logic [DIST_W-1:0]     side_dist_y,
    input  logic [DIST_W-1:0]     delta_dist_x,
    input  logic [DIST_W-1:0]     delta_dist_y,
    input  logic signed [1:0]     step_sign_x,
    input  logic signed [1:0]     step_sign_y,
    input  logic signed [31:0]    ray_dir_x,
    input  logic signed [31:0]    ray_dir_y,
    input  logic [31:0]           player_pos_x,
    input  logic [31:0]           player_pos_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIST_W-1:0]     wall_distance,
    output logic [QUOT_W-1:0]     line_height,
    output logic [ROW_W-1:0]      draw_start_row,
    output logic [ROW_W-1:0]      draw_end_row,
    output logic [TEX_W-1:0]      texture_index,
    output logic [COL_W-1:0]      texture_column
);

    localparam int FW      = 2 * FRACTION_BITS;
    localparam int DIV_N   = QUOT_W / 2;
    localparam int STAGES  = DIV_N + 3;
    localparam int RW      = 18;
    localparam logic [63:0] NUM = 64'(SCREEN_HEIGHT) << FRACTION_BITS;
    localparam logic [DIST_W-1:0] NUM_HI = DIST_W'(NUM >> QUOT_W);
    localparam logic [QUOT_W-1:0] NUM_LO = NUM[QUOT_W-1:0];
    localparam logic [RW-1:0] HALF_SCREEN = RW'(SCREEN_HEIGHT / 2);
    localparam logic [RW-1:0] SCREEN_ROWS = RW'(SCREEN_HEIGHT);
    localparam logic [RW-1:0] LAST_ROW    = RW'(SCREEN_HEIGHT - 1);

    typedef struct packed {
        logic [DIST_W-1:0] wall_dist;
        logic [TEX_W-1:0]  tex;
        logic              mirror;
        logic [31:0]       pos;
        logic [31:0]       dir;
        logic [TEXW_W-1:0] width;
        logic [FW-1:0]     frac;
        logic [COL_W-1:0]  col;
        logic              ovf;
        logic [DIST_W:0]   rem;
        logic [QUOT_W-1:0] quot;
        logic [ROW_W-1:0]  start_row;
        logic [ROW_W-1:0]  end_row;
    } stage_t;

    logic [TEXW_W-1:0] west_width_reg;
    logic [TEXW_W-1:0] east_width_reg;
    logic [TEXW_W-1:0] north_width_reg;
    logic [TEXW_W-1:0] south_width_reg;

    stage_t            stage_reg  [STAGES];
    stage_t            stage_next [STAGES];
    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   rdy;

    // config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            west_width_reg  <= 13'd64;
            east_width_reg  <= 13'd64;
            north_width_reg <= 13'd64;
            south_width_reg <= 13'd64;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WEST_WIDTH:  west_width_reg  <= cfg_data;
                CFG_EAST_WIDTH:  east_width_reg  <= cfg_data;
                CFG_NORTH_WIDTH: north_width_reg <= cfg_data;
                CFG_SOUTH_WIDTH: south_width_reg <= cfg_data;
                default:         west_width_reg  <= west_width_reg;
            endcase
        end
    end

    // ready chain, a stage moves when it is empty or its successor moves
    assign rdy[STAGES] = out_ready;
    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_rdy
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    endgenerate
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            if (rdy[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // stage 0: distance, face choice, width
    always_comb
    begin
        logic [DIST_W-1:0] sd;
        logic [DIST_W-1:0] dd;
        logic [TEXW_W-1:0] w_raw;
        stage_t            s;
        s = '0;
        sd = hit_side ? side_dist_y : side_dist_x;
        dd = hit_side ? delta_dist_y : delta_dist_x;
        s.wall_dist = (sd >= dd) ? (sd - dd) : '0;
        if (!hit_side)
        begin
            s.tex = (step_sign_x == 2'sd1) ? TEX_WEST : TEX_EAST;
        end
        else
        begin
            s.tex = (step_sign_y == 2'sd1) ? TEX_NORTH : TEX_SOUTH;
        end
        case (tex_t'(s.tex))
            TEX_WEST:  w_raw = west_width_reg;
            TEX_EAST:  w_raw = east_width_reg;
            TEX_NORTH: w_raw = north_width_reg;
            default:   w_raw = south_width_reg;
        endcase
        if (w_raw == '0)
        begin
            s.width = TEX_WIDTH_MIN;
        end
        else if (w_raw > TEX_WIDTH_MAX)
        begin
            s.width = TEX_WIDTH_MAX;
        end
        else
        begin
            s.width = w_raw;
        end
        s.mirror = hit_side ? ray_dir_y[31] : (!ray_dir_x[31] && (ray_dir_x != '0));
        s.pos = hit_side ? player_pos_x : player_pos_y;
        s.dir = hit_side ? ray_dir_x : ray_dir_y;
        stage_next[0] = s;
    end

    // stage 1: hit product (low bits only), divider setup
    always_comb
    begin
        logic signed [64:0] prod;
        stage_t             s;
        s = stage_reg[0];
        prod = $signed({1'b0, s.wall_dist}) * $signed(s.dir);
        s.frac = prod[FW-1:0];
        s.ovf  = (s.wall_dist == '0) || (s.wall_dist <= NUM_HI);
        s.rem  = {1'b0, NUM_HI};
        s.quot = '0;
        stage_next[1] = s;
    end

    // stages 2 .. DIV_N+1: divider steps, texture column work alongside
    generate
        for (k = 0; k < DIV_N; k++)
        begin : g_div
            logic [DIST_W:0]   rem_o;
            logic [QUOT_W-1:0] quot_o;

            rcwp_div_step u_step (
                .rem_in   (stage_reg[k+1].rem),
                .quot_in  (stage_reg[k+1].quot),
                .divisor  (stage_reg[k+1].wall_dist),
                .num_bits (NUM_LO[QUOT_W-1-2*k -: 2]),
                .rem_out  (rem_o),
                .quot_out (quot_o)
            );

            always_comb
            begin
                logic [63:0]        hit;
                logic [FW+TEXW_W-1:0] fw;
                logic [TEXW_W-1:0]  mcol;
                stage_t             s;
                s = stage_reg[k+1];
                hit = '0;
                fw = '0;
                mcol = '0;
                if (k == 0)
                begin
                    hit = (64'(s.pos) << FRACTION_BITS) + 64'(s.frac);
                    s.frac = hit[FW-1:0];
                end
                else if (k == 1)
                begin
                    fw = (FW+TEXW_W)'(s.frac) * (FW+TEXW_W)'(s.width);
                    s.col = fw[FW+COL_W-1:FW];
                end
                else if (k == 2)
                begin
                    mcol = s.width - TEXW_W'(1) - TEXW_W'(s.col);
                    if (s.mirror)
                    begin
                        s.col = mcol[COL_W-1:0];
                    end
                end
                s.rem  = rem_o;
                s.quot = quot_o;
                stage_next[k+2] = s;
            end
        end
    endgenerate

    // last stage: saturate height, clamp rows
    always_comb
    begin
        logic [QUOT_W-1:0] lh;
        logic [RW-1:0]     half;
        logic [RW-1:0]     st;
        logic [RW-1:0]     en;
        stage_t            s;
        s = stage_reg[DIV_N+1];
        lh = s.ovf ? '1 : s.quot;
        half = RW'(lh >> 1);
        st = (half >= HALF_SCREEN) ? '0 : (HALF_SCREEN - half);
        en = HALF_SCREEN + half;
        if (en >= SCREEN_ROWS)
        begin
            en = LAST_ROW;
        end
        s.quot      = lh;
        s.start_row = st[ROW_W-1:0];
        s.end_row   = en[ROW_W-1:0];
        stage_next[STAGES-1] = s;
    end

    assign out_valid      = valid_reg[STAGES-1];
    assign wall_distance  = stage_reg[STAGES-1].wall_dist;
    assign line_height    = stage_reg[STAGES-1].quot;
    assign draw_start_row = stage_reg[STAGES-1].start_row;
    assign draw_end_row   = stage_reg[STAGES-1].end_row;
    assign texture_index  = stage_reg[STAGES-1].tex;
    assign texture_column = stage_reg[STAGES-1].col;

endmodule
